FILE: rtl/core/e2q_pkg.sv
package e2q_pkg;

    // Q60 working format for angles, sines, cosines and products
    typedef logic signed [63:0] t_q60;

    localparam int unsigned Q_FRAC = 60;
    localparam t_q60 PI_Q         = 64'sh3243F6A8885A308D;
    localparam t_q60 HALF_PI_Q    = 64'sh1921FB54442D1846;
    localparam t_q60 QUARTER_PI_Q = 64'sh0C90FDAA22168C23;
    localparam t_q60 GAIN_INV_Q   = 64'sh09B74EDA8435E5A6;

    // latency of the fixed-point multiplier
    localparam int unsigned MUL_LAT = 4;

    // APB address width: four registers at 4-byte spacing
    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FIRST_AXIS     = 2'd0,
        REG_PARITY_ODD     = 2'd1,
        REG_AXIS_REPEATED  = 2'd2,
        REG_ROTATING_FRAME = 2'd3
    } t_reg_idx;

    // quaternion slot (1 x, 2 y, 3 z) of the i, j and k parts
    typedef struct packed {
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] k;
    } t_axis_map;

    localparam logic [1:0] NEXT_AXIS [0:3] = '{2'd1, 2'd2, 2'd0, 2'd1};

    // atan(2^-i) in Q60 from the truncated Taylor series; elaboration only
    function automatic t_q60 atan_q(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] term;
        int unsigned n;
        sum = '0;
        if (i == 0) begin
            return QUARTER_PI_Q;
        end
        for (n = 0; n < 64; n++) begin
            if (i * (2 * n + 1) <= Q_FRAC) begin
                term = (64'd1 << (Q_FRAC - i * (2 * n + 1))) / 64'(2 * n + 1);
                if (n[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return t_q60'(sum);
    endfunction

    // component placement for an axis sequence; unused code 3 acts as x
    function automatic t_axis_map axis_map(input logic [1:0] fa, input logic p);
        t_axis_map m;
        logic [1:0] fi;
        logic [1:0] ii;
        fi = (fa == 2'd3) ? 2'd0 : fa;
        ii = fi + 2'd1;
        m.i = ii;
        m.j = NEXT_AXIS[2'(ii + {1'b0, p} - 2'd1)] + 2'd1;
        m.k = NEXT_AXIS[2'(ii - {1'b0, p})] + 2'd1;
        return m;
    endfunction

endpackage

FILE: rtl/core/e2q_mul.sv
module e2q_mul
    import e2q_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q60 i_a,
    input  t_q60 i_b,
    output t_q60 o_p
);

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg1;
    logic [63:0]  r_p00;
    logic [63:0]  r_p01;
    logic [63:0]  r_p10;
    logic [63:0]  r_p11;
    logic         r_neg2;
    logic [62:0]  r_mag;
    logic         r_neg3;
    t_q60         r_p;
    logic [127:0] n_sum;

    // partial products summed with the rounding half of Q60
    always_comb begin
        n_sum = {r_p11, 64'd0} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
              + {64'd0, r_p00} + (128'd1 << (Q_FRAC - 1));
    end

    // magnitudes, 32x32 partial products, round, sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
            r_neg2 <= r_neg1;
            r_mag  <= n_sum[Q_FRAC+62:Q_FRAC];
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -t_q60'({1'b0, r_mag}) : t_q60'({1'b0, r_mag});
        end
    end

    assign o_p = r_p;

endmodule

FILE: rtl/core/e2q_cordic.sv
module e2q_cordic
    import e2q_pkg::*;
#(
    parameter int STAGES = 28
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_q60 i_angle,
    output t_q60 o_sin,
    output t_q60 o_cos
);

    t_q60 r_x [0:STAGES];
    t_q60 r_y [0:STAGES];
    t_q60 r_z [0:STAGES];
    logic r_flip [0:STAGES];
    t_q60 r_sin;
    t_q60 r_cos;

    // fold into +-pi/2, remembering a sign flip of both results
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_INV_Q;
            r_y[0] <= '0;
            if (i_angle > HALF_PI_Q) begin
                r_z[0]    <= i_angle - PI_Q;
                r_flip[0] <= 1'b1;
            end else if (i_angle < -HALF_PI_Q) begin
                r_z[0]    <= i_angle + PI_Q;
                r_flip[0] <= 1'b1;
            end else begin
                r_z[0]    <= i_angle;
                r_flip[0] <= 1'b0;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam t_q60 ATAN = atan_q(s);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[s+1] <= r_flip[s];
                if (!r_z[s][63]) begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] - ATAN;
                end else begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_z[s+1] <= r_z[s] + ATAN;
                end
            end
        end
    end

    // undo the fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES];
            r_cos <= r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: rtl/core/euler_to_quaternion_top.sv
// A beat passes the input register, the unrolled CORDIC, the first multipliers,
// the operand register, the second multipliers and the placement and output registers.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset (synchronous, active low) empties the pipeline and sets the axis
// sequence to static xyz.
module euler_to_quaternion_top
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH   = 32,
    parameter int QUAT_WIDTH    = 32,
    parameter int CORDIC_STAGES = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_first,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_second,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle_third,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [QUAT_WIDTH-1:0]  o_quat_w,
    output logic signed [QUAT_WIDTH-1:0]  o_quat_x,
    output logic signed [QUAT_WIDTH-1:0]  o_quat_y,
    output logic signed [QUAT_WIDTH-1:0]  o_quat_z
);

    localparam int SH_IN  = 63 - ANGLE_WIDTH;
    localparam int SH_OUT = 62 - QUAT_WIDTH;
    localparam int LAT    = CORDIC_STAGES + 6 + 2 * MUL_LAT;
    localparam t_q60 QMAX = (64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1;
    localparam t_q60 QMIN = -(64'sd1 <<< (QUAT_WIDTH - 1));
    localparam t_q60 HALF_OUT = 64'sd1 <<< (SH_OUT - 1);

    // configuration
    logic [1:0] r_first_axis;
    logic       r_parity_odd;
    logic       r_axis_repeated;
    logic       r_rotating_frame;
    t_axis_map  axm;

    logic       en;
    logic [LAT-1:0] r_vld;

    t_q60 h0, h1, h2;
    t_q60 r_h0, r_h1, r_h2;
    t_q60 si, ci, sj, cj, sk, ck;
    t_q60 cc, cs, sc, ss;
    t_q60 r_cj_d [0:MUL_LAT-1];
    t_q60 r_sj_d [0:MUL_LAT-1];
    t_q60 r_ma [0:7];
    t_q60 r_mb [0:7];
    t_q60 m [0:7];
    t_q60 qa, qi, qj, qk;
    t_q60 r_q [0:3];
    t_q60 rnd [0:3];
    logic signed [QUAT_WIDTH-1:0] r_quat [0:3];

    assign pready = 1'b1;
    assign axm    = axis_map(r_first_axis, r_parity_odd);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_axis     <= 2'd0;
            r_parity_odd     <= 1'b0;
            r_axis_repeated  <= 1'b0;
            r_rotating_frame <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_FIRST_AXIS:     r_first_axis     <= pwdata[1:0];
                REG_PARITY_ODD:     r_parity_odd     <= pwdata[0];
                REG_AXIS_REPEATED:  r_axis_repeated  <= pwdata[0];
                REG_ROTATING_FRAME: r_rotating_frame <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FIRST_AXIS:     prdata = {30'd0, r_first_axis};
            REG_PARITY_ODD:     prdata = {31'd0, r_parity_odd};
            REG_AXIS_REPEATED:  prdata = {31'd0, r_axis_repeated};
            REG_ROTATING_FRAME: prdata = {31'd0, r_rotating_frame};
            default:            prdata = '0;
        endcase
    end

    // global advance: everything moves unless the output beat is stuck
    assign en         = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // half angles in Q60, with frame swap and parity negation
    always_comb begin
        h0 = t_q60'(i_angle_first)  <<< SH_IN;
        h1 = t_q60'(i_angle_second) <<< SH_IN;
        h2 = t_q60'(i_angle_third)  <<< SH_IN;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h0 <= r_rotating_frame ? h2 : h0;
            r_h2 <= r_rotating_frame ? h0 : h2;
            r_h1 <= r_parity_odd ? -h1 : h1;
        end
    end

    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_i (
        .i_clk(i_clk), .i_en(en), .i_angle(r_h0), .o_sin(si), .o_cos(ci)
    );
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_j (
        .i_clk(i_clk), .i_en(en), .i_angle(r_h1), .o_sin(sj), .o_cos(cj)
    );
    e2q_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_k (
        .i_clk(i_clk), .i_en(en), .i_angle(r_h2), .o_sin(sk), .o_cos(ck)
    );

    // first product level
    e2q_mul u_mul_cc (.i_clk(i_clk), .i_en(en), .i_a(ci), .i_b(ck), .o_p(cc));
    e2q_mul u_mul_cs (.i_clk(i_clk), .i_en(en), .i_a(ci), .i_b(sk), .o_p(cs));
    e2q_mul u_mul_sc (.i_clk(i_clk), .i_en(en), .i_a(si), .i_b(ck), .o_p(sc));
    e2q_mul u_mul_ss (.i_clk(i_clk), .i_en(en), .i_a(si), .i_b(sk), .o_p(ss));

    // middle-angle terms wait for the first products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cj_d[0] <= cj;
            r_sj_d[0] <= sj;
            for (int d = 1; d < MUL_LAT; d++) begin
                r_cj_d[d] <= r_cj_d[d-1];
                r_sj_d[d] <= r_sj_d[d-1];
            end
        end
    end

    // operand pairs; the repeated-axis form zeroes every odd product
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_axis_repeated) begin
                r_ma[0] <= r_cj_d[MUL_LAT-1]; r_mb[0] <= cc - ss;
                r_ma[1] <= r_cj_d[MUL_LAT-1]; r_mb[1] <= '0;
                r_ma[2] <= r_cj_d[MUL_LAT-1]; r_mb[2] <= cs + sc;
                r_ma[3] <= r_cj_d[MUL_LAT-1]; r_mb[3] <= '0;
                r_ma[4] <= r_sj_d[MUL_LAT-1]; r_mb[4] <= cc + ss;
                r_ma[5] <= r_sj_d[MUL_LAT-1]; r_mb[5] <= '0;
                r_ma[6] <= r_sj_d[MUL_LAT-1]; r_mb[6] <= cs - sc;
                r_ma[7] <= r_sj_d[MUL_LAT-1]; r_mb[7] <= '0;
            end else begin
                r_ma[0] <= r_cj_d[MUL_LAT-1]; r_mb[0] <= cc;
                r_ma[1] <= r_sj_d[MUL_LAT-1]; r_mb[1] <= ss;
                r_ma[2] <= r_cj_d[MUL_LAT-1]; r_mb[2] <= sc;
                r_ma[3] <= r_sj_d[MUL_LAT-1]; r_mb[3] <= cs;
                r_ma[4] <= r_cj_d[MUL_LAT-1]; r_mb[4] <= ss;
                r_ma[5] <= r_sj_d[MUL_LAT-1]; r_mb[5] <= cc;
                r_ma[6] <= r_cj_d[MUL_LAT-1]; r_mb[6] <= cs;
                r_ma[7] <= r_sj_d[MUL_LAT-1]; r_mb[7] <= sc;
            end
        end
    end

    // second product level
    for (genvar g = 0; g < 8; g++) begin : g_mul2
        e2q_mul u_mul (
            .i_clk(i_clk), .i_en(en), .i_a(r_ma[g]), .i_b(r_mb[g]), .o_p(m[g])
        );
    end

    // combine and place the parts
    always_comb begin
        qa = m[0] + m[1];
        qi = m[2] - m[3];
        qj = r_parity_odd ? -(m[4] + m[5]) : (m[4] + m[5]);
        qk = m[6] - m[7];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q[0] <= qa;
            for (int s = 1; s < 4; s++) begin
                if (2'(s) == axm.i) begin
                    r_q[s] <= qi;
                end else if (2'(s) == axm.j) begin
                    r_q[s] <= qj;
                end else begin
                    r_q[s] <= qk;
                end
            end
        end
    end

    // round to the output format and saturate
    always_comb begin
        for (int s = 0; s < 4; s++) begin
            rnd[s] = (r_q[s] + HALF_OUT) >>> SH_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < 4; s++) begin
                if (rnd[s] > QMAX) begin
                    r_quat[s] <= QMAX[QUAT_WIDTH-1:0];
                end else if (rnd[s] < QMIN) begin
                    r_quat[s] <= QMIN[QUAT_WIDTH-1:0];
                end else begin
                    r_quat[s] <= rnd[s][QUAT_WIDTH-1:0];
                end
            end
        end
    end

    assign o_quat_w = r_quat[0];
    assign o_quat_x = r_quat[1];
    assign o_quat_y = r_quat[2];
    assign o_quat_z = r_quat[3];

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output beat valid right after reset");

    // a stuck output beat freezes the input side
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // an output beat only appears from the stage before it
    a_vld_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[LAT-2]))
        else $error("output valid without a preceding stage beat");

endmodule
